@@ sv/bpuis_pkg.sv @@
// Shared types, constants and functions for the Bloom-prefiltered unique ID set.
// No dependencies; imported by every module of the block except bpuis_ram.
`default_nettype none

package bpuis_pkg;

    // Store size and number of Bloom probes taken from the CRC
    localparam int CAPACITY    = 64;
    localparam int HASH_PROBES = 4;

    // Derived widths: the count must hold CAPACITY itself
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int ID_W    = 256;
    localparam int BLOOM_W = 256;
    localparam int NBYTES  = ID_W / 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Depth of the queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CRC,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_DECIDE
    } t_back_state;

    // Word 3 first so that byte 0 lands in bits 7:0 of the packed whole
    typedef struct packed {
        logic [63:0] id_word3;
        logic [63:0] id_word2;
        logic [63:0] id_word1;
        logic [63:0] id_word0;
    } t_id_in;

    typedef struct packed {
        t_status    status;
        logic       bloom_hit;
        logic [6:0] entry_count;
    } t_result;

    // Classified item passed from front to back end
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [31:0]     crc;
    } t_work;

    // One reflected CRC-32 byte step, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // True when every probed Bloom bit is set
    function automatic logic probe_hit(input logic [BLOOM_W-1:0] bits, input logic [31:0] crc);
        logic h;
        h = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (k < HASH_PROBES) begin
                h = h & bits[crc[k*8 +: 8]];
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ sv/bpuis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpuis_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/bpuis_front.sv @@
// Front end: accepts identifiers and computes their CRC-32, one byte a cycle.
// Depends on bpuis_pkg.
`default_nettype none

module bpuis_front
    import bpuis_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_id_in i_id,
    output logic        o_full,
    output logic        o_q_push,
    output t_work       o_q_data,
    input  wire logic   i_q_full
);

    t_front_state    r_state, n_state;
    logic [ID_W-1:0] r_id, n_id;
    logic [31:0]     r_crc, n_crc;
    logic [4:0]      r_byte, n_byte;

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_id   <= n_id;
        r_crc  <= n_crc;
        r_byte <= n_byte;
    end

    // Next state: take item, step CRC over 32 bytes, hand over to queue
    always_comb begin
        n_state       = r_state;
        n_id          = r_id;
        n_crc         = r_crc;
        n_byte        = r_byte;
        o_full        = 1'b1;
        o_q_push      = 1'b0;
        o_q_data.id   = r_id;
        o_q_data.crc  = r_crc ^ CRC_INIT;
        case (r_state)
            FR_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_id    = i_id;
                    n_crc   = CRC_INIT;
                    n_byte  = 5'd0;
                    n_state = FR_CRC;
                end
            end
            FR_CRC: begin
                n_crc  = crc_byte(r_crc, r_id[{r_byte, 3'b000} +: 8]);
                n_byte = r_byte + 5'd1;
                if (r_byte == 5'(NBYTES - 1)) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bpuis_queue.sv @@
// Short queue of classified items between front and back end.
// Depends on bpuis_pkg.
`default_nettype none

module bpuis_queue
    import bpuis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_data,
    output logic       o_full,
    output logic       o_vld,
    output t_work      o_data,
    input  wire logic  i_pop
);

    t_work              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_fill;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_fill == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_vld   = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + (Q_PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - (Q_PTR_W + 1)'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/bpuis_back.sv @@
// Back end: Bloom check, linear search of the store, insert and result register.
// Depends on bpuis_pkg and bpuis_ram.
`default_nettype none

module bpuis_back
    import bpuis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_vld,
    input  wire t_work i_q_data,
    output logic       o_q_pop,
    output logic       o_empty,
    output t_result    o_res,
    input  wire logic  i_pop
);

    t_back_state        r_state, n_state;
    t_work              r_work, n_work;
    logic               r_hit, n_hit;
    logic               r_found, n_found;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_issued_all, n_issued_all;
    logic               r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BLOOM_W-1:0] r_bloom, n_bloom;
    logic               r_out_vld, n_out_vld;
    t_result            r_out, n_out;

    logic               slot_free;
    logic               ram_wr_en;
    logic [ID_W-1:0]    ram_rd_data;

    // Identifier store
    bpuis_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_work.id),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign slot_free = !r_out_vld || i_pop;
    assign o_empty   = !r_out_vld;
    assign o_res     = r_out;

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_count   <= '0;
            r_bloom   <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bloom   <= n_bloom;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= n_cmp_vld;
        end
        r_work       <= n_work;
        r_hit        <= n_hit;
        r_found      <= n_found;
        r_idx        <= n_idx;
        r_issued_all <= n_issued_all;
        r_out        <= n_out;
    end

    // Sequencer: classify, search (one read issued per cycle), decide
    always_comb begin
        n_state      = r_state;
        n_work       = r_work;
        n_hit        = r_hit;
        n_found      = r_found;
        n_idx        = r_idx;
        n_issued_all = r_issued_all;
        n_cmp_vld    = 1'b0;
        n_count      = r_count;
        n_bloom      = r_bloom;
        n_out_vld    = r_out_vld;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        ram_wr_en    = 1'b0;

        // Result taken by the consumer
        if (i_pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop      = 1'b1;
                    n_work       = i_q_data;
                    n_hit        = probe_hit(r_bloom, i_q_data.crc);
                    n_found      = 1'b0;
                    n_idx        = '0;
                    n_issued_all = 1'b0;
                    if (n_hit && (r_count != '0)) begin
                        n_state = BK_SEARCH;
                    end else begin
                        n_state = BK_DECIDE;
                    end
                end
            end
            BK_SEARCH: begin
                // Issue next read; its read data arrives in the following cycle
                if (!r_issued_all) begin
                    n_idx        = r_idx + CNT_W'(1);
                    n_issued_all = ((r_idx + CNT_W'(1)) == r_count);
                    n_cmp_vld    = 1'b1;
                end
                if (r_cmp_vld && (ram_rd_data == r_work.id)) begin
                    n_found   = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_state   = BK_DECIDE;
                end else if (r_cmp_vld && r_issued_all) begin
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                if (slot_free) begin
                    n_out.bloom_hit = r_hit;
                    if (r_found) begin
                        n_out.status = ST_PRESENT;
                    end else if (r_count >= CNT_W'(CAPACITY)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_out.status = ST_INSERTED;
                        ram_wr_en    = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        for (int k = 0; k < 4; k++) begin
                            if (k < HASH_PROBES) begin
                                n_bloom[r_work.crc[k*8 +: 8]] = 1'b1;
                            end
                        end
                    end
                    n_out.entry_count = 7'(n_count);
                    n_out_vld         = 1'b1;
                    n_state           = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Checks on store bookkeeping and search control
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count beyond capacity");

    a_present_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == ST_PRESENT)) |-> r_out.bloom_hit)
        else $error("already-present result without Bloom hit");

    a_search_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SEARCH) |-> (r_hit && (r_count != '0)))
        else $error("search started without Bloom hit");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BK_DECIDE) && slot_free && !r_found && (r_count < CNT_W'(CAPACITY)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance stored count");

endmodule

`default_nettype wire

@@ sv/bloom_prefiltered_unique_id_set_top.sv @@
// Path: CRC over the identifier (one byte a cycle) in the front end, then queue hand-over, classify
// and update in the back end on a Bloom miss; a Bloom hit adds a linear search of the stored entries.
// Overlap: front and back run concurrently through a two-entry queue; the front end bounds the rate
// on a Bloom miss, while a hit with a long search of up to 64 stored entries can make the back end the bound.
// Reset (synchronous, active low) clears the Bloom bitmap, stored count, queue, front and back state and
// result valid flag; the identifier store is not cleared and is only compared below the stored count.
`default_nettype none

module bloom_prefiltered_unique_id_set_top
    import bpuis_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   push,
    input  wire t_id_in i_id,
    output logic        full,
    output logic        empty,
    input  wire logic   pop,
    output t_result     o_res
);

    logic  fq_push;
    t_work fq_data;
    logic  fq_full;
    logic  qb_vld;
    t_work qb_data;
    logic  qb_pop;

    // CRC front end
    bpuis_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_id     (i_id),
        .o_full   (full),
        .o_q_push (fq_push),
        .o_q_data (fq_data),
        .i_q_full (fq_full)
    );

    // Decoupling queue
    bpuis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (fq_full),
        .o_vld   (qb_vld),
        .o_data  (qb_data),
        .i_pop   (qb_pop)
    );

    // Set back end
    bpuis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (qb_vld),
        .i_q_data (qb_data),
        .o_q_pop  (qb_pop),
        .o_empty  (empty),
        .o_res    (o_res),
        .i_pop    (pop)
    );

endmodule

`default_nettype wire
